// File: rtl/glyph_quad_layout_with_kerning_top_assert.svh
// ----------------------------------------------------------------------------
// Glyph quad layout assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_LAYOUT_WITH_KERNING_TOP_ASSERT_SVH
`define GLYPH_QUAD_LAYOUT_WITH_KERNING_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GQK_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GQK_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/gqk_pkg.sv
// ----------------------------------------------------------------------------
// Glyph quad layout package
// Shared constants, codes and saturation helpers of the glyph quad layout.
// ----------------------------------------------------------------------------
package gqk_pkg;

	localparam int CODE_BITS_DEF = 8;
	localparam int METRIC_BITS_DEF = 12;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_W = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_H = 3'd5;

	localparam logic [1:0] OP_GLYPH = 2'd0;
	localparam logic [1:0] OP_KERN = 2'd1;
	localparam logic [1:0] OP_DRAW = 2'd2;

	localparam logic [1:0] CORNER_RB = 2'd0;
	localparam logic [1:0] CORNER_RT = 2'd1;
	localparam logic [1:0] CORNER_LT = 2'd2;
	localparam logic [1:0] CORNER_LB = 2'd3;

	localparam int CUR_W = 40;
	localparam int SVAL_W = 41;
	localparam int MAG_W = 61;
	localparam int POS_W = 64;
	localparam int TEX_W = 48;

	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, 60'b0};
	localparam logic signed [TEX_W-1:0] ONE_Q24 = 48'sd16777216;

	function automatic logic [31:0] sat32(input logic signed [POS_W-1:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [23:0] sat24(input logic signed [TEX_W-1:0] v);
		logic [23:0] r;
		if (v < 48'sd0) begin
			r = 24'd0;
		end else if (v > 48'sd16777215) begin
			r = 24'hff_ffff;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [CUR_W-1:0] sat_cursor(input logic signed [SVAL_W-1:0] v);
		logic signed [CUR_W-1:0] r;
		if (v > 41'sd549755813887) begin
			r = 40'sh7f_ffff_ffff;
		end else if (v < -41'sd549755813888) begin
			r = 40'sh80_0000_0000;
		end else begin
			r = v[CUR_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/gqk_ram.sv
// ----------------------------------------------------------------------------
// Glyph quad layout RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module gqk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/glyph_quad_layout_with_kerning_top.sv
// ----------------------------------------------------------------------------
// Glyph quad layout with kerning
// Items enter on item_valid/item_stall. A glyph or kerning load is written
// into its table at the accepting edge and the input is ready again in the
// next cycle. A draw item reads both tables, applies the pair kerning and
// emits four vertex items on vertex_valid/vertex_stall, corner 0 first.
// One shared multiply unit computes fourteen scaled products in turn,
// each through the S_MUL_A, S_MUL_B and S_MUL_C states; the block then
// emits the vertices and takes the next item once the fourth vertex is
// loaded into the output register, so no item enters while a draw is busy.
// A stalled vertex holds the output register; the block waits in the
// emit phase until the register frees up.
// After reset a clearing pass zeroes the kerning and glyph tables, one
// entry per cycle for 2^(2*CODE_BITS) entries (65536 by default); no item
// is accepted during the pass, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`include "glyph_quad_layout_with_kerning_top_assert.svh"

module glyph_quad_layout_with_kerning_top import gqk_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF,
	parameter int METRIC_BITS = METRIC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            operation,
	input  logic [7:0]            char_code,
	input  logic [7:0]            second_code,
	input  logic                  text_start,
	input  logic [11:0]           atlas_x,
	input  logic [11:0]           atlas_y,
	input  logic [11:0]           glyph_width,
	input  logic [11:0]           glyph_height,
	input  logic signed [11:0]    x_offset,
	input  logic signed [11:0]    y_offset,
	input  logic [11:0]           x_advance,
	input  logic signed [7:0]     kern_amount,
	output logic                  vertex_valid,
	input  logic                  vertex_stall,
	output logic signed [31:0]    vertex_x,
	output logic signed [31:0]    vertex_y,
	output logic [23:0]           tex_u,
	output logic [23:0]           tex_v,
	output logic [31:0]           vertex_number,
	output logic [1:0]            corner,
	output logic                  last_of_quad
);

	localparam int KERN_AW = 2 * CODE_BITS;
	localparam int GLYPH_DEPTH = 1 << CODE_BITS;
	localparam int KERN_DEPTH = 1 << KERN_AW;

	localparam logic [3:0] STEP_A1 = 4'd0;
	localparam logic [3:0] STEP_A2 = 4'd1;
	localparam logic [3:0] STEP_B1 = 4'd2;
	localparam logic [3:0] STEP_B2 = 4'd3;
	localparam logic [3:0] STEP_BY1 = 4'd4;
	localparam logic [3:0] STEP_BY2 = 4'd5;
	localparam logic [3:0] STEP_W1 = 4'd6;
	localparam logic [3:0] STEP_W2 = 4'd7;
	localparam logic [3:0] STEP_H1 = 4'd8;
	localparam logic [3:0] STEP_H2 = 4'd9;
	localparam logic [3:0] STEP_U = 4'd10;
	localparam logic [3:0] STEP_U2 = 4'd11;
	localparam logic [3:0] STEP_V = 4'd12;
	localparam logic [3:0] STEP_V2 = 4'd13;

	localparam logic [1:0] SH_0 = 2'd0;
	localparam logic [1:0] SH_8 = 2'd1;
	localparam logic [1:0] SH_16 = 2'd2;

	typedef struct packed {
		logic [METRIC_BITS-1:0] ax;
		logic [METRIC_BITS-1:0] ay;
		logic [METRIC_BITS-1:0] w;
		logic [METRIC_BITS-1:0] h;
		logic [METRIC_BITS-1:0] xo;
		logic [METRIC_BITS-1:0] yo;
		logic [METRIC_BITS-1:0] adv;
	} glyph_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [23:0]               scale_q;
	logic signed [31:0]        origin_x_q;
	logic signed [31:0]        origin_y_q;
	logic [11:0]               baseline_q;
	logic [23:0]               inv_w_q;
	logic [23:0]               inv_h_q;

	logic [KERN_AW-1:0]        clr_cnt_q;
	logic [3:0]                step_q;
	logic [1:0]                k_q;
	logic                      vertex_valid_q;
	logic signed [CUR_W-1:0]   cursor_q;
	logic [CODE_BITS-1:0]      prev_code_q;
	logic [31:0]               vcount_q;

	logic [CODE_BITS-1:0]      code_q;
	logic                      start_q;
	logic [55:0]               p_lo_q;
	logic [52:0]               p_hi_q;
	logic [1:0]                sh_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          res_q;
	logic signed [POS_W-1:0]   cx_q;
	logic signed [POS_W-1:0]   cy_q;
	logic [MAG_W-1:0]          cw_q;
	logic [MAG_W-1:0]          chm_q;
	logic signed [TEX_W-1:0]   u_q;
	logic signed [TEX_W-1:0]   u2_q;
	logic signed [TEX_W-1:0]   v_q;
	logic signed [TEX_W-1:0]   v2_q;

	logic signed [31:0]        vx_q;
	logic signed [31:0]        vy_q;
	logic [23:0]               tu_q;
	logic [23:0]               tv_q;
	logic [31:0]               vnum_q;
	logic [1:0]                corner_q;
	logic                      last_q;

	logic                      item_acc;
	logic                      clearing;
	logic [CODE_BITS-1:0]      code_in;
	logic                      glyph_we;
	logic [CODE_BITS-1:0]      glyph_waddr;
	glyph_t                    glyph_wdata;
	logic                      draw_re;
	logic [$bits(glyph_t)-1:0] glyph_rdata;
	glyph_t                    g;
	logic                      kern_we;
	logic [KERN_AW-1:0]        kern_waddr;
	logic [7:0]                kern_wdata;
	logic [7:0]                kern_rdata;

	logic                      chained;
	logic signed [SVAL_W-1:0]  sval;
	logic [SVAL_W-1:0]         sval_mag;
	logic [MAG_W-1:0]          op_mag;
	logic [23:0]               op_f;
	logic [1:0]                op_sh;
	logic [85:0]               full;
	logic [85:0]               shifted;
	logic [MAG_W-1:0]          res_next;
	logic signed [POS_W-1:0]   res_s;
	logic signed [TEX_W-1:0]   res_t;
	logic signed [POS_W-1:0]   px_right;
	logic signed [POS_W-1:0]   py_bottom;
	logic signed [POS_W-1:0]   kx;
	logic signed [POS_W-1:0]   ky;
	logic signed [TEX_W-1:0]   ku;
	logic signed [TEX_W-1:0]   kv;
	logic                      emit_load;

	assign clearing = (state_q == S_CLEAR);
	assign item_stall = (state_q != S_IDLE);
	assign item_acc = item_valid && !item_stall;
	assign code_in = char_code[CODE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 24'd65536;
			origin_x_q <= '0;
			origin_y_q <= '0;
			baseline_q <= '0;
			inv_w_q <= 24'd32768;
			inv_h_q <= 24'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[23:0];
				REG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				REG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				REG_BASELINE: baseline_q <= cfg_data[11:0];
				REG_INV_W: inv_w_q <= cfg_data[23:0];
				REG_INV_H: inv_h_q <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	assign glyph_we = clearing || (item_acc && operation == OP_GLYPH);
	assign glyph_waddr = clearing ? clr_cnt_q[CODE_BITS-1:0] : code_in;
	always_comb begin
		glyph_wdata.ax = METRIC_BITS'(atlas_x);
		glyph_wdata.ay = METRIC_BITS'(atlas_y);
		glyph_wdata.w = METRIC_BITS'(glyph_width);
		glyph_wdata.h = METRIC_BITS'(glyph_height);
		glyph_wdata.xo = METRIC_BITS'(x_offset);
		glyph_wdata.yo = METRIC_BITS'(y_offset);
		glyph_wdata.adv = METRIC_BITS'(x_advance);
		if (clearing) begin
			glyph_wdata = '0;
		end
	end

	assign kern_we = clearing || (item_acc && operation == OP_KERN);
	assign kern_waddr = clearing ? clr_cnt_q : {code_in, second_code[CODE_BITS-1:0]};
	assign kern_wdata = clearing ? 8'd0 : kern_amount;
	assign draw_re = item_acc && operation == OP_DRAW;

	gqk_ram #(
		.WIDTH($bits(glyph_t)),
		.DEPTH(GLYPH_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (glyph_we),
		.waddr(glyph_waddr),
		.wdata(glyph_wdata),
		.re   (draw_re),
		.raddr(code_in),
		.rdata(glyph_rdata)
	);

	gqk_ram #(
		.WIDTH(8),
		.DEPTH(KERN_DEPTH)
	) u_kern_ram (
		.clk  (clk),
		.we   (kern_we),
		.waddr(kern_waddr),
		.wdata(kern_wdata),
		.re   (draw_re),
		.raddr({prev_code_q, code_in}),
		.rdata(kern_rdata)
	);

	assign g = glyph_t'(glyph_rdata);

	assign chained = step_q[0] && (step_q < STEP_U);

	always_comb begin
		unique case (step_q)
			STEP_A1: sval = SVAL_W'(cursor_q) + SVAL_W'($signed(g.xo));
			STEP_B1: sval = $signed(SVAL_W'(baseline_q));
			STEP_BY1: sval = $signed(SVAL_W'(baseline_q)) - SVAL_W'($signed(g.yo));
			STEP_W1, STEP_U2: sval = $signed(SVAL_W'(g.w));
			STEP_H1, STEP_V2: sval = $signed(SVAL_W'(g.h));
			STEP_U: sval = $signed(SVAL_W'(g.ax));
			STEP_V: sval = $signed(SVAL_W'(g.ay));
			default: sval = '0;
		endcase
	end

	assign sval_mag = sval[SVAL_W-1] ? SVAL_W'(-sval) : SVAL_W'(sval);
	assign op_mag = chained ? res_q : MAG_W'(sval_mag);

	always_comb begin
		if (chained) begin
			op_f = scale_q;
			op_sh = SH_16;
		end else begin
			unique case (step_q)
				STEP_A1, STEP_W1, STEP_U, STEP_U2: op_f = inv_w_q;
				default: op_f = inv_h_q;
			endcase
			op_sh = (step_q < STEP_U) ? SH_8 : SH_0;
		end
	end

	assign full = 86'({p_hi_q, 32'b0}) + 86'(p_lo_q);

	always_comb begin
		unique case (sh_q)
			SH_8: shifted = full >> 8;
			SH_16: shifted = full >> 16;
			default: shifted = full;
		endcase
	end

	assign res_next = (shifted > 86'(MAG_CAP)) ? MAG_CAP : shifted[MAG_W-1:0];
	assign res_s = neg_q ? -$signed(POS_W'(res_q)) : $signed(POS_W'(res_q));
	assign res_t = $signed(res_q[TEX_W-1:0]);

	assign px_right = cx_q + $signed(POS_W'(cw_q));
	assign py_bottom = cy_q - $signed(POS_W'(chm_q));

	always_comb begin
		unique case (k_q)
			CORNER_RB: begin
				kx = px_right;
				ky = py_bottom;
				ku = u2_q;
				kv = v2_q;
			end
			CORNER_RT: begin
				kx = px_right;
				ky = cy_q;
				ku = u2_q;
				kv = v_q;
			end
			CORNER_LT: begin
				kx = cx_q;
				ky = cy_q;
				ku = u_q;
				kv = v_q;
			end
			CORNER_LB: begin
				kx = cx_q;
				ky = py_bottom;
				ku = u_q;
				kv = v2_q;
			end
		endcase
	end

	assign emit_load = (state_q == S_EMIT) && (!vertex_valid_q || !vertex_stall);

	always_ff @(posedge clk) begin
		if (draw_re) begin
			code_q <= code_in;
			start_q <= text_start;
		end
		if (state_q == S_MUL_A) begin
			p_lo_q <= 56'(op_mag[31:0]) * 56'(op_f);
			p_hi_q <= 53'(op_mag[MAG_W-1:32]) * 53'(op_f);
			sh_q <= op_sh;
			if (!chained) begin
				neg_q <= sval[SVAL_W-1];
			end
		end
		if (state_q == S_MUL_B) begin
			res_q <= res_next;
		end
		if (state_q == S_MUL_C) begin
			unique case (step_q)
				STEP_A2: cx_q <= POS_W'(origin_x_q) + res_s;
				STEP_B2: cy_q <= POS_W'(origin_y_q) - $signed(POS_W'(res_q));
				STEP_BY2: cy_q <= cy_q + res_s;
				STEP_W2: cw_q <= res_q;
				STEP_H2: chm_q <= res_q;
				STEP_U: u_q <= res_t;
				STEP_U2: u2_q <= u_q + res_t;
				STEP_V: v_q <= ONE_Q24 - res_t;
				STEP_V2: v2_q <= v_q - res_t;
				default: begin
				end
			endcase
		end
		if (emit_load) begin
			vx_q <= $signed(sat32(kx));
			vy_q <= $signed(sat32(ky));
			tu_q <= sat24(ku);
			tv_q <= sat24(kv);
			vnum_q <= vcount_q + 32'(k_q);
			corner_q <= k_q;
			last_q <= (k_q == CORNER_LB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			step_q <= STEP_A1;
			k_q <= CORNER_RB;
			vertex_valid_q <= 1'b0;
			cursor_q <= '0;
			prev_code_q <= '0;
			vcount_q <= '0;
		end else begin
			if (emit_load) begin
				vertex_valid_q <= 1'b1;
			end else if (vertex_valid_q && !vertex_stall) begin
				vertex_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (draw_re) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (start_q) begin
						cursor_q <= '0;
					end else begin
						cursor_q <= sat_cursor(SVAL_W'(cursor_q) +
							SVAL_W'($signed(kern_rdata)));
					end
					step_q <= STEP_A1;
					state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					state_q <= S_MUL_C;
				end
				S_MUL_C: begin
					if (step_q == STEP_V2) begin
						k_q <= CORNER_RB;
						state_q <= S_EMIT;
					end else begin
						step_q <= step_q + 1'b1;
						state_q <= S_MUL_A;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						if (k_q == CORNER_LB) begin
							cursor_q <= sat_cursor(SVAL_W'(cursor_q) +
								$signed(SVAL_W'(g.adv)));
							vcount_q <= vcount_q + 32'd4;
							prev_code_q <= code_q;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign vertex_valid = vertex_valid_q;
	assign vertex_x = vx_q;
	assign vertex_y = vy_q;
	assign tex_u = tu_q;
	assign tex_v = tv_q;
	assign vertex_number = vnum_q;
	assign corner = corner_q;
	assign last_of_quad = last_q;

	`GQK_ASSERT_IMP(a_corner_tracks_number, vertex_valid, corner == vertex_number[1:0], "corner out of step with vertex number")
	`GQK_ASSERT_IMP(a_no_vertex_while_clearing, state_q == S_CLEAR, !vertex_valid, "vertex shown during clearing pass")
	`GQK_ASSERT_NXT(a_draw_starts_lookup, draw_re, state_q == S_LOOK, "draw item did not start table lookup")
	`GQK_ASSERT_NXT(a_last_vertex_frees_input, emit_load && k_q == CORNER_LB, !item_stall, "input not ready after fourth vertex")

endmodule

// File: dv/glyph_quad_layout_with_kerning_top_tb.sv
// ----------------------------------------------------------------------------
// Glyph quad layout testbench
// Loads glyphs and kerning pairs, draws characters under several register
// settings and checks every vertex against a fixed-point layout predictor.
// ----------------------------------------------------------------------------
module glyph_quad_layout_with_kerning_top_tb;
	import gqk_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [23:0] u;
		logic [23:0] v;
		logic [31:0] num;
		logic [1:0]  crn;
		logic        last;
	} vertex_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  code;
		logic [7:0]  code2;
		logic        start;
		logic [11:0] ax, ay, w, h;
		logic [11:0] xo, yo;
		logic [11:0] adv;
		logic [7:0]  kern;
	} glyph_item_t;

	class layout_scoreboard;
		logic [23:0] scl, inv_w, inv_h;
		logic [11:0] base;
		longint org_x, org_y;
		logic [11:0] g_ax[256], g_ay[256], g_w[256], g_h[256];
		logic [11:0] g_xo[256], g_yo[256], g_adv[256];
		logic [7:0] kern_tab[int];
		longint pen;
		logic [7:0] prev_code;
		logic [31:0] vcount;
		vertex_t pending[$];
		int errors;

		function new();
			scl = 24'd65536;
			inv_w = 24'd32768;
			inv_h = 24'd32768;
			base = 0;
			org_x = 0;
			org_y = 0;
			for (int i = 0; i < 256; i++) begin
				g_ax[i] = 0; g_ay[i] = 0; g_w[i] = 0; g_h[i] = 0;
				g_xo[i] = 0; g_yo[i] = 0; g_adv[i] = 0;
			end
			pen = 0;
			prev_code = 0;
			vcount = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				REG_SCALE: scl = d[23:0];
				REG_ORIGIN_X: org_x = longint'(signed'(d));
				REG_ORIGIN_Y: org_y = longint'(signed'(d));
				REG_BASELINE: base = d[11:0];
				REG_INV_W: inv_w = d[23:0];
				REG_INV_H: inv_h = d[23:0];
				default: ;
			endcase
		endfunction

		function longint scaled_mul(longint a, logic [23:0] f, int sh);
			logic neg;
			logic [63:0] mag, lo, hi, r, cap;
			neg = a < 0;
			mag = neg ? -a : a;
			cap = 64'd1 << 60;
			lo = {32'd0, mag[31:0]} * {40'd0, f};
			hi = (mag >> 32) * {40'd0, f};
			if (hi >= (cap >> (32 - sh))) r = cap;
			else begin
				r = (hi << (32 - sh)) + (lo >> sh);
				if (r > cap) r = cap;
			end
			return neg ? -longint'(r) : longint'(r);
		endfunction

		function longint scale_term(longint p, logic [23:0] rc);
			return scaled_mul(scaled_mul(p, rc, 8), scl, 16);
		endfunction

		function longint clamp_pen(longint v);
			if (v > (64'sd1 <<< 39) - 1) return (64'sd1 <<< 39) - 1;
			if (v < -(64'sd1 <<< 39)) return -(64'sd1 <<< 39);
			return v;
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		function logic [23:0] clamp24(longint v);
			if (v < 0) return 0;
			if (v > 64'sd16777215) return 24'hff_ffff;
			return v[23:0];
		endfunction

		function void note_item(glyph_item_t it);
			longint k, cx, cy, cw, ch, u, u2, v, v2, xo, yo;
			longint px[4], py[4], pu[4], pv[4];
			vertex_t e;
			if (it.op == OP_GLYPH) begin
				g_ax[it.code] = it.ax; g_ay[it.code] = it.ay;
				g_w[it.code] = it.w; g_h[it.code] = it.h;
				g_xo[it.code] = it.xo; g_yo[it.code] = it.yo;
				g_adv[it.code] = it.adv;
			end else if (it.op == OP_KERN) begin
				kern_tab[{it.code, it.code2}] = it.kern;
			end else if (it.op == OP_DRAW) begin
				if (it.start) pen = 0;
				else begin
					k = kern_tab.exists({prev_code, it.code}) ?
						longint'(signed'(kern_tab[{prev_code, it.code}])) : 0;
					pen = clamp_pen(pen + k);
				end
				xo = longint'(signed'(g_xo[it.code]));
				yo = longint'(signed'(g_yo[it.code]));
				cx = org_x + scale_term(pen + xo, inv_w);
				cy = org_y - scale_term(longint'(base), inv_h)
					+ scale_term(longint'(base) - yo, inv_h);
				cw = scale_term(longint'(g_w[it.code]), inv_w);
				ch = -scale_term(longint'(g_h[it.code]), inv_h);
				u = longint'(g_ax[it.code]) * longint'(inv_w);
				u2 = u + longint'(g_w[it.code]) * longint'(inv_w);
				v = (64'sd1 <<< 24) - longint'(g_ay[it.code]) * longint'(inv_h);
				v2 = v - longint'(g_h[it.code]) * longint'(inv_h);
				px = '{cx + cw, cx + cw, cx, cx};
				py = '{cy + ch, cy, cy, cy + ch};
				pu = '{u2, u2, u, u};
				pv = '{v2, v, v, v2};
				for (int i = 0; i < 4; i++) begin
					e.vx = clamp32(px[i]);
					e.vy = clamp32(py[i]);
					e.u = clamp24(pu[i]);
					e.v = clamp24(pv[i]);
					e.num = vcount + i;
					e.crn = 2'(i);
					e.last = (i == 3);
					pending.insert(pending.size(), e);
				end
				pen = clamp_pen(pen + longint'(g_adv[it.code]));
				vcount += 4;
				prev_code = it.code;
			end
		endfunction

		function void check_vertex(vertex_t a);
			vertex_t e;
			if (pending.size() == 0) begin
				$error("unexpected vertex number %0d", a.num);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.vx !== e.vx) begin
				$error("vertex_x exp %h got %h", e.vx, a.vx); errors++;
			end
			if (a.vy !== e.vy) begin
				$error("vertex_y exp %h got %h", e.vy, a.vy); errors++;
			end
			if (a.u !== e.u) begin
				$error("tex_u exp %h got %h", e.u, a.u); errors++;
			end
			if (a.v !== e.v) begin
				$error("tex_v exp %h got %h", e.v, a.v); errors++;
			end
			if (a.num !== e.num) begin
				$error("vertex_number exp %0d got %0d", e.num, a.num); errors++;
			end
			if (a.crn !== e.crn) begin
				$error("corner exp %0d got %0d", e.crn, a.crn); errors++;
			end
			if (a.last !== e.last) begin
				$error("last_of_quad exp %0d got %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	logic item_valid = 0;
	logic item_stall;
	logic [1:0] operation = 0;
	logic [7:0] char_code = 0, second_code = 0;
	logic text_start = 0;
	logic [11:0] atlas_x = 0, atlas_y = 0, glyph_width = 0, glyph_height = 0;
	logic signed [11:0] x_offset = 0, y_offset = 0;
	logic [11:0] x_advance = 0;
	logic signed [7:0] kern_amount = 0;
	logic vertex_valid;
	logic vertex_stall = 0;
	logic signed [31:0] vertex_x, vertex_y;
	logic [23:0] tex_u, tex_v;
	logic [31:0] vertex_number;
	logic [1:0] corner;
	logic last_of_quad;

	layout_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;

	glyph_quad_layout_with_kerning_top i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && vertex_valid && !vertex_stall)
			sb.check_vertex('{vertex_x, vertex_y, tex_u, tex_v, vertex_number, corner,
				last_of_quad});
		vertex_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic send_item(glyph_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		operation <= it.op;
		char_code <= it.code;
		second_code <= it.code2;
		text_start <= it.start;
		atlas_x <= it.ax;
		atlas_y <= it.ay;
		glyph_width <= it.w;
		glyph_height <= it.h;
		x_offset <= it.xo;
		y_offset <= it.yo;
		x_advance <= it.adv;
		kern_amount <= it.kern;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic drain();
		item_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic glyph_item_t rand_item(logic [1:0] op, logic [7:0] code);
		glyph_item_t it;
		it.op = op;
		it.code = code;
		it.code2 = 8'($urandom);
		it.start = ($urandom_range(7) == 0);
		it.ax = 12'($urandom); it.ay = 12'($urandom);
		it.w = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(64));
		it.h = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(64));
		it.xo = 12'($urandom); it.yo = 12'($urandom);
		it.adv = 12'($urandom);
		it.kern = 8'($urandom);
		return it;
	endfunction

	task automatic random_phase(int n);
		glyph_item_t it;
		logic [7:0] codes[8];
		for (int i = 0; i < 8; i++) codes[i] = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1: it = rand_item(OP_GLYPH, codes[$urandom_range(7)]);
				2: begin
					it = rand_item(OP_KERN, codes[$urandom_range(7)]);
					it.code2 = codes[$urandom_range(7)];
				end
				3: it = rand_item(OP_UNUSED, 8'($urandom));
				4: it = rand_item(OP_DRAW, 8'($urandom));
				default: it = rand_item(OP_DRAW, codes[$urandom_range(7)]);
			endcase
			send_item(it);
		end
	endtask

	glyph_item_t d;

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		d = rand_item(OP_DRAW, 8'd7);
		d.start = 0;
		send_item(d);
		d = rand_item(OP_GLYPH, 8'd0);
		d.ax = 0; d.ay = 0; d.w = 12'hfff; d.h = 12'hfff;
		d.xo = 12'h800; d.yo = 12'h7ff; d.adv = 12'hfff;
		send_item(d);
		d = rand_item(OP_GLYPH, 8'hff);
		d.ax = 12'hfff; d.ay = 12'hfff; d.w = 12'hfff; d.h = 12'hfff;
		d.xo = 12'h7ff; d.yo = 12'h800; d.adv = 0;
		send_item(d);
		d = rand_item(OP_KERN, 8'hff);
		d.code2 = 8'h00; d.kern = 8'h80;
		send_item(d);
		d = rand_item(OP_KERN, 8'h00);
		d.code2 = 8'hff; d.kern = 8'h7f;
		send_item(d);
		d = rand_item(OP_UNUSED, 8'h55);
		send_item(d);
		d = rand_item(OP_DRAW, 8'hff); d.start = 1; send_item(d);
		d = rand_item(OP_DRAW, 8'h00); d.start = 0; send_item(d);
		d = rand_item(OP_DRAW, 8'hff); d.start = 0; send_item(d);
		d = rand_item(OP_DRAW, 8'h33); d.start = 0; send_item(d);
		drain();

		write_reg(REG_SCALE, 32'h00ff_ffff);
		write_reg(REG_ORIGIN_X, 32'h7fff_ff00);
		write_reg(REG_ORIGIN_Y, 32'h8000_0100);
		write_reg(REG_BASELINE, 32'h0000_0fff);
		write_reg(REG_INV_W, 32'h00ff_ffff);
		write_reg(REG_INV_H, 32'h00ff_ffff);
		for (int i = 0; i < 6; i++) begin
			d = rand_item(OP_DRAW, i[0] ? 8'hff : 8'h00);
			d.start = (i == 0);
			send_item(d);
		end
		drain();

		write_reg(REG_SCALE, 0);
		write_reg(REG_ORIGIN_X, 32'h8000_0000);
		write_reg(REG_ORIGIN_Y, 32'h7fff_ffff);
		write_reg(REG_BASELINE, 0);
		write_reg(REG_INV_W, 0);
		write_reg(REG_INV_H, 0);
		d = rand_item(OP_DRAW, 8'hff); d.start = 1; send_item(d);
		d = rand_item(OP_DRAW, 8'h00); d.start = 0; send_item(d);
		drain();

		send_idle_pct = 23; recv_idle_pct = 83;
		write_reg(REG_SCALE, 32'h0001_0000);
		write_reg(REG_ORIGIN_X, $urandom);
		write_reg(REG_ORIGIN_Y, $urandom);
		write_reg(REG_BASELINE, $urandom_range(200));
		write_reg(REG_INV_W, 32'd16384);
		write_reg(REG_INV_H, 32'd16384);
		random_phase(120);
		drain();

		send_idle_pct = 83; recv_idle_pct = 23;
		write_reg(REG_SCALE, $urandom);
		write_reg(REG_ORIGIN_X, $urandom);
		write_reg(REG_ORIGIN_Y, $urandom);
		write_reg(REG_BASELINE, $urandom);
		write_reg(REG_INV_W, $urandom_range(70000));
		write_reg(REG_INV_H, $urandom_range(70000));
		random_phase(110);
		drain();

		send_idle_pct = 0; recv_idle_pct = 0;
		write_reg(REG_SCALE, $urandom_range(24'h30000));
		write_reg(REG_INV_W, $urandom);
		write_reg(REG_INV_H, $urandom);
		random_phase(120);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/gqk_pkg.sv
rtl/gqk_ram.sv
rtl/glyph_quad_layout_with_kerning_top.sv
dv/glyph_quad_layout_with_kerning_top_tb.sv
